@@ rtl/tbdl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbdl_pkg
// Shared types, command and register codes, and queue sizing for the
// three-button debounce and long-press unit.
// ----------------------------------------------------------------------------
package tbdl_pkg;

  localparam int NUM_BTN    = 3;
  localparam int QUEUE_SIZE = 8;
  localparam int PTR_W      = (QUEUE_SIZE > 2) ? $clog2(QUEUE_SIZE) : 1;

  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_POLL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd3;

  // Event actions
  localparam logic ACT_PRESS = 1'b0;
  localparam logic ACT_LONG  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [1:0] button;
  } evt_t;

  typedef struct packed {
    logic              raw_last;
    logic              stable_level;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic              long_done;
  } btn_state_t;

  typedef btn_state_t [NUM_BTN-1:0] btn_row_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(QUEUE_SIZE - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

@@ rtl/tbdl_intf.sv @@
// ----------------------------------------------------------------------------
// tbdl_intf
// Handshake channels of the button unit: command input, event output and
// configuration write.
// ----------------------------------------------------------------------------
interface tbdl_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [tbdl_pkg::CMD_W-1:0] command;
  logic                       left_level;
  logic                       right_level;
  logic                       center_level;
  logic [tbdl_pkg::TIME_W-1:0] now_ms;

  modport source(output valid, command, left_level, right_level, center_level, now_ms,
                 input ready);
  modport sink(input valid, command, left_level, right_level, center_level, now_ms,
               output ready);
endinterface

interface tbdl_evt_if;
  logic       valid;
  logic       ready;
  logic       event_found;
  logic [1:0] button;
  logic       action;

  modport source(output valid, event_found, button, action, input ready);
  modport sink(input valid, event_found, button, action, output ready);
endinterface

interface tbdl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbdl_pkg::CFG_IDX_W-1:0]  index;
  logic [tbdl_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/three_button_debounce_long_press_unit.sv @@
// ----------------------------------------------------------------------------
// three_button_debounce_long_press_unit
// Debounces left, right and center buttons and queues press / long-press
// events for later pop.
// ----------------------------------------------------------------------------
// One command is taken per clock while no pop waits in the command stage.
// An accepted command is registered into the command stage and executed
// there; a pop result is loaded into the output register, or into the skid
// entry while the output register holds a result not yet taken.
// Per-button state lives in a one-row state memory read through a
// write-first read register, so a command that follows directly sees the row
// written back by its predecessor. Throughput is one command per cycle; it
// drops only when pop results back up: the output register plus one skid
// entry hold results, and a pop waits while the skid entry is occupied.
// Polls and inits never stall in the command stage, though a command queued
// behind a waiting pop waits with it. The event queue holds QUEUE_SIZE-1
// events and drops new ones when full. Configuration writes are always
// accepted, as cfg.ready is tied high.
// ----------------------------------------------------------------------------
module three_button_debounce_long_press_unit (
  input logic      clk,
  input logic      rst,
  tbdl_cmd_if.sink cmd,
  tbdl_evt_if.source evt,
  tbdl_cfg_if.sink cfg
);

  typedef struct packed {
    logic       found;
    logic [1:0] button;
    logic       action;
  } result_t;

  // Configuration
  logic        active_low;
  logic [2:0]  button_enable;
  logic [15:0] debounce_ms;
  logic [15:0] long_press_ms;

  // Command stage
  logic                             s1_valid;
  logic [tbdl_pkg::CMD_W-1:0]       s1_cmd;
  logic [tbdl_pkg::NUM_BTN-1:0]     s1_level;
  logic [tbdl_pkg::TIME_W-1:0]      s1_now;
  logic                             s1_pop;
  logic                             s1_go;

  // Button state memory
  tbdl_pkg::btn_row_t btn_mem;
  logic               mem_valid;
  tbdl_pkg::btn_row_t btn_rd;
  tbdl_pkg::btn_row_t row_next;
  logic               state_we;

  // Event queue
  tbdl_pkg::evt_t event_store [tbdl_pkg::QUEUE_SIZE];
  tbdl_pkg::ptr_t write_ptr;
  tbdl_pkg::ptr_t read_ptr;
  tbdl_pkg::ptr_t write_ptr_next;
  logic           [tbdl_pkg::NUM_BTN-1:0] ev_we;
  tbdl_pkg::ptr_t ev_addr [tbdl_pkg::NUM_BTN];
  tbdl_pkg::evt_t ev_data [tbdl_pkg::NUM_BTN];
  logic           queue_nonempty;

  // Output register and skid entry
  result_t new_res;
  logic    new_res_valid;
  result_t out_res;
  logic    out_valid;
  result_t skid_res;
  logic    skid_valid;
  logic    out_take;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low    <= 1'b1;
      button_enable <= 3'd7;
      debounce_ms   <= 16'd50;
      long_press_ms <= 16'd800;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tbdl_pkg::CFG_ACTIVE_LOW:    active_low    <= cfg.data[0];
        tbdl_pkg::CFG_BUTTON_ENABLE: button_enable <= cfg.data[2:0];
        tbdl_pkg::CFG_DEBOUNCE_MS:   debounce_ms   <= cfg.data;
        tbdl_pkg::CFG_LONG_PRESS_MS: long_press_ms <= cfg.data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Command stage
  // --------------------------------------------------------------------------
  assign s1_pop    = (s1_cmd == tbdl_pkg::CMD_POP);
  assign s1_go     = s1_valid && (!s1_pop || !skid_valid);
  assign cmd.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd   <= cmd.command;
      s1_level <= {cmd.center_level, cmd.right_level, cmd.left_level};
      s1_now   <= cmd.now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Button update and event enqueue
  // --------------------------------------------------------------------------
  always_comb begin
    tbdl_pkg::btn_state_t       st;
    logic                       lvl;
    logic                       fire;
    tbdl_pkg::evt_t             code;
    logic [tbdl_pkg::TIME_W-1:0] since_change;
    logic [tbdl_pkg::TIME_W-1:0] since_press;
    tbdl_pkg::ptr_t             wp;
    tbdl_pkg::ptr_t             nxt;

    row_next = btn_rd;
    wp       = write_ptr;
    ev_we    = '0;
    for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) begin
      st           = btn_rd[b];
      lvl          = s1_level[b];
      fire         = 1'b0;
      code.button  = 2'(b);
      code.action  = tbdl_pkg::ACT_PRESS;
      since_change = '0;
      since_press  = '0;
      if (s1_cmd == tbdl_pkg::CMD_INIT) begin
        st.raw_last     = lvl;
        st.stable_level = lvl;
        st.change_time  = s1_now;
      end else if (s1_cmd == tbdl_pkg::CMD_POLL && button_enable[b]) begin
        if (lvl != st.raw_last) begin
          st.raw_last    = lvl;
          st.change_time = s1_now;
        end
        since_change = s1_now - st.change_time;
        if (since_change >= {16'b0, debounce_ms}) begin
          if (lvl != st.stable_level) begin
            st.stable_level = lvl;
            if (lvl ^ active_low) begin
              st.press_time = s1_now;
              st.long_done  = 1'b0;
            end else if (!st.long_done) begin
              fire = 1'b1;
            end
          end
          since_press = s1_now - st.press_time;
          if ((st.stable_level ^ active_low) && !st.long_done &&
              since_press >= {16'b0, long_press_ms}) begin
            st.long_done = 1'b1;
            fire         = 1'b1;
            code.action  = tbdl_pkg::ACT_LONG;
          end
        end
      end
      row_next[b] = st;

      // drop the event when the ring is full
      nxt        = tbdl_pkg::ptr_inc(wp);
      ev_addr[b] = wp;
      ev_data[b] = code;
      if (fire && nxt != read_ptr) begin
        ev_we[b] = 1'b1;
        wp       = nxt;
      end
    end
    write_ptr_next = wp;
  end

  assign state_we = s1_go && (s1_cmd == tbdl_pkg::CMD_POLL || s1_cmd == tbdl_pkg::CMD_INIT);

  // State memory with write-first read register
  always_ff @(posedge clk) begin
    if (state_we) begin
      btn_mem <= row_next;
    end
    btn_rd <= state_we ? row_next : (mem_valid ? btn_mem : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= 1'b0;
    end else if (state_we) begin
      mem_valid <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Event queue
  // --------------------------------------------------------------------------
  assign queue_nonempty = (read_ptr != write_ptr);

  always_ff @(posedge clk) begin
    if (s1_go && s1_cmd == tbdl_pkg::CMD_POLL) begin
      for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) begin
        if (ev_we[b]) begin
          event_store[ev_addr[b]] <= ev_data[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else if (s1_go) begin
      if (s1_cmd == tbdl_pkg::CMD_POLL) begin
        write_ptr <= write_ptr_next;
      end
      if (s1_pop && queue_nonempty) begin
        read_ptr <= tbdl_pkg::ptr_inc(read_ptr);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result output: register plus skid entry
  // --------------------------------------------------------------------------
  assign new_res_valid  = s1_go && s1_pop;
  assign new_res.found  = queue_nonempty;
  assign new_res.button = queue_nonempty ? event_store[read_ptr].button : 2'd0;
  assign new_res.action = queue_nonempty ? event_store[read_ptr].action : 1'b0;
  assign out_take       = out_valid && evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      out_valid  <= skid_valid || new_res_valid;
      skid_valid <= 1'b0;
    end else if (new_res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (new_res_valid) begin
      skid_res <= new_res;
    end
  end

  assign evt.valid       = out_valid;
  assign evt.event_found = out_res.found;
  assign evt.button      = out_res.button;
  assign evt.action      = out_res.action;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_state_forward: assert property (@(posedge clk) disable iff (rst)
    state_we |=> btn_rd == $past(row_next))
    else $error("state read register missed the written-back row");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && !evt.event_found) |-> (evt.button == 2'd0 && !evt.action))
    else $error("empty pop carries nonzero event fields");

  a_pop_keeps_write_ptr: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_pop) |=> write_ptr == $past(write_ptr))
    else $error("write pointer moved on a pop");

endmodule

@@ dv/tb_three_button_debounce_long_press_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_button_debounce_long_press_unit
// Self-checking bench for the three-button debounce and long-press unit.
// Commands go in through the command channel, and a behavioral copy of the
// debouncers and the event ring predicts every pop result. Results are
// compared in order, field by field. Directed checks cover time wrap, bounce,
// long press and queue overflow. Random traffic then runs under several
// register settings with random command gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_three_button_debounce_long_press_unit;

  localparam logic [tbdl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT       = 23;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic found;
    tbdl_pkg::evt_t ev;
  } pop_result_t;

  logic clk;
  logic rst;

  tbdl_cmd_if cmd_if();
  tbdl_evt_if evt_if();
  tbdl_cfg_if cfg_if();

  three_button_debounce_long_press_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .evt(evt_if),
    .cfg(cfg_if)
  );

  // Register copy
  logic        cfg_active_low;
  logic [2:0]  cfg_enable;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_long_press;

  // Per-button debouncer copy
  logic        btn_raw[tbdl_pkg::NUM_BTN];
  logic        btn_stable[tbdl_pkg::NUM_BTN];
  logic        btn_long_done[tbdl_pkg::NUM_BTN];
  logic [31:0] btn_change_t[tbdl_pkg::NUM_BTN];
  logic [31:0] btn_press_t[tbdl_pkg::NUM_BTN];

  // Event ring copy
  tbdl_pkg::evt_t evq_store[tbdl_pkg::QUEUE_SIZE];
  int unsigned    evq_wr;
  int unsigned    evq_rd;

  pop_result_t expected_pops[$];

  bit          no_gaps;
  logic [31:0] t_now;
  logic        intent_pressed[tbdl_pkg::NUM_BTN];

  int fail_count;
  int n_polls, n_pops, n_inits, n_ignored;
  int n_found, n_empty, n_dropped, n_settings, n_pauses;
  int stall_cycles;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ERROR: %s", $time, msg);
  endfunction

  function automatic void reset_model();
    cfg_active_low = 1'b1;
    cfg_enable     = 3'd7;
    cfg_debounce   = 16'd50;
    cfg_long_press = 16'd800;
    for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) begin
      btn_raw[b]       = 1'b0;
      btn_stable[b]    = 1'b0;
      btn_long_done[b] = 1'b0;
      btn_change_t[b]  = '0;
      btn_press_t[b]   = '0;
    end
    evq_wr = 0;
    evq_rd = 0;
  endfunction

  function automatic bit level_is_pressed(logic lvl);
    return cfg_active_low ? (lvl == 1'b0) : (lvl == 1'b1);
  endfunction

  function automatic void queue_event(int b, logic act);
    int unsigned nxt;
    nxt = (evq_wr + 1) % tbdl_pkg::QUEUE_SIZE;
    // drop when the ring is full
    if (nxt == evq_rd) begin
      n_dropped++;
      return;
    end
    evq_store[evq_wr].button = 2'(b);
    evq_store[evq_wr].action = act;
    evq_wr = nxt;
  endfunction

  function automatic void service_button(int b, logic lvl, logic [31:0] now);
    logic [31:0] since_change;
    logic [31:0] since_press;
    if (lvl != btn_raw[b]) begin
      btn_raw[b]      = lvl;
      btn_change_t[b] = now;
    end
    since_change = now - btn_change_t[b];
    if (since_change < {16'd0, cfg_debounce}) return;
    if (lvl != btn_stable[b]) begin
      btn_stable[b] = lvl;
      if (level_is_pressed(lvl)) begin
        btn_press_t[b]   = now;
        btn_long_done[b] = 1'b0;
      end else if (!btn_long_done[b]) begin
        queue_event(b, tbdl_pkg::ACT_PRESS);
      end
    end
    since_press = now - btn_press_t[b];
    if (level_is_pressed(btn_stable[b]) && !btn_long_done[b] &&
        since_press >= {16'd0, cfg_long_press}) begin
      btn_long_done[b] = 1'b1;
      queue_event(b, tbdl_pkg::ACT_LONG);
    end
  endfunction

  // lv: bit0 left, bit1 right, bit2 center
  function automatic void apply_command(logic [1:0] cmd, logic [2:0] lv, logic [31:0] now);
    pop_result_t res;
    case (cmd)
      tbdl_pkg::CMD_POLL: begin
        n_polls++;
        for (int b = 0; b < tbdl_pkg::NUM_BTN; b++)
          if (cfg_enable[b]) service_button(b, lv[b], now);
      end
      tbdl_pkg::CMD_POP: begin
        n_pops++;
        res = '0;
        if (evq_rd != evq_wr) begin
          res.found = 1'b1;
          res.ev    = evq_store[evq_rd];
          evq_rd    = (evq_rd + 1) % tbdl_pkg::QUEUE_SIZE;
        end
        expected_pops.push_back(res);
      end
      tbdl_pkg::CMD_INIT: begin
        n_inits++;
        for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) begin
          btn_raw[b]      = lv[b];
          btn_stable[b]   = lv[b];
          btn_change_t[b] = now;
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic issue_command(logic [1:0] cmd, logic [2:0] lv, logic [31:0] now);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        cmd_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    cmd_if.command      = cmd;
    cmd_if.left_level   = lv[0];
    cmd_if.right_level  = lv[1];
    cmd_if.center_level = lv[2];
    cmd_if.now_ms       = now;
    cmd_if.valid        = 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    apply_command(cmd, lv, now);
    @(negedge clk);
  endtask

  // Wait for every pending pop, then let any in-flight poll finish.
  task automatic settle_block();
    cmd_if.valid = 1'b0;
    while (expected_pops.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [tbdl_pkg::CFG_IDX_W-1:0] idx,
                           logic [tbdl_pkg::CFG_DATA_W-1:0] val);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      tbdl_pkg::CFG_ACTIVE_LOW:    cfg_active_low = val[0];
      tbdl_pkg::CFG_BUTTON_ENABLE: cfg_enable     = val[2:0];
      tbdl_pkg::CFG_DEBOUNCE_MS:   cfg_debounce   = val;
      tbdl_pkg::CFG_LONG_PRESS_MS: cfg_long_press = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_setting(logic al, logic [2:0] en, logic [15:0] deb, logic [15:0] lp);
    settle_block();
    write_reg(tbdl_pkg::CFG_ACTIVE_LOW, {15'd0, al});
    write_reg(tbdl_pkg::CFG_BUTTON_ENABLE, {13'd0, en});
    write_reg(tbdl_pkg::CFG_DEBOUNCE_MS, deb);
    write_reg(tbdl_pkg::CFG_LONG_PRESS_MS, lp);
    n_settings++;
  endtask

  // Mostly well-formed press/hold/release sequences with bounce, plus noise.
  task automatic run_random_traffic(int n_items, int step_max, bit pause_midway);
    int   roll;
    logic [2:0] lv;
    logic pressed_lvl;
    pressed_lvl = cfg_active_low ? 1'b0 : 1'b1;
    t_now = $urandom;
    for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) intent_pressed[b] = 1'b0;
    issue_command(tbdl_pkg::CMD_INIT, {3{~pressed_lvl}}, t_now);
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) begin
        // hold the sender until every pop has been answered
        cmd_if.valid = 1'b0;
        while (expected_pops.size() != 0) @(negedge clk);
        n_pauses++;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        case ($urandom_range(0, 2))
          0: issue_command(CMD_UNUSED, 3'($urandom), $urandom);
          1: issue_command(tbdl_pkg::CMD_INIT, 3'($urandom), t_now);
          default: begin
            t_now = $urandom;
            issue_command(tbdl_pkg::CMD_POLL, 3'($urandom), t_now);
          end
        endcase
      end else if (roll < 32) begin
        issue_command(tbdl_pkg::CMD_POP, 3'($urandom), $urandom);
      end else begin
        for (int b = 0; b < tbdl_pkg::NUM_BTN; b++) begin
          if ($urandom_range(0, 99) < 8) intent_pressed[b] = ~intent_pressed[b];
          lv[b] = intent_pressed[b] ? pressed_lvl : ~pressed_lvl;
          if ($urandom_range(0, 99) < 10) lv[b] = ~lv[b];
        end
        t_now = t_now + $urandom_range(0, step_max);
        issue_command(tbdl_pkg::CMD_POLL, lv, t_now);
      end
    end
  endtask

  // Reset settings: left bounces across the time wrap, then a clean release.
  task automatic test_debounce_across_wrap();
    issue_command(tbdl_pkg::CMD_INIT, 3'b111, 32'hFFFF_FFF0);
    issue_command(tbdl_pkg::CMD_POLL, 3'b110, 32'hFFFF_FFF0);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'hFFFF_FFF4);
    issue_command(tbdl_pkg::CMD_POLL, 3'b110, 32'hFFFF_FFF8);
    issue_command(tbdl_pkg::CMD_POLL, 3'b110, 32'h0000_0030);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'h0000_0040);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'h0000_0080);
    issue_command(tbdl_pkg::CMD_POP, 3'b000, 32'h0000_0000);
  endtask

  task automatic test_long_press_hold();
    issue_command(tbdl_pkg::CMD_POLL, 3'b011, 32'h0000_0100);
    issue_command(tbdl_pkg::CMD_POLL, 3'b011, 32'h0000_0140);
    issue_command(tbdl_pkg::CMD_POLL, 3'b011, 32'h0000_0460);
    issue_command(tbdl_pkg::CMD_POP, 3'b111, 32'hFFFF_FFFF);
  endtask

  // Zero debounce and zero long-press time: every press fires three long
  // presses at once, so the ring overflows after a few presses.
  task automatic test_queue_overflow();
    apply_setting(1'b0, 3'd7, 16'd0, 16'd0);
    issue_command(tbdl_pkg::CMD_INIT, 3'b000, 32'h0000_1234);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'h0000_1234);
    issue_command(tbdl_pkg::CMD_POLL, 3'b000, 32'h0000_1234);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'h0000_1234);
    issue_command(tbdl_pkg::CMD_POLL, 3'b000, 32'h0000_1234);
    issue_command(tbdl_pkg::CMD_POLL, 3'b111, 32'h0000_1234);
    issue_command(CMD_UNUSED, 3'b101, 32'hA5A5_5A5A);
    repeat (tbdl_pkg::QUEUE_SIZE) issue_command(tbdl_pkg::CMD_POP, 3'b010, 32'h5A5A_A5A5);
  endtask

  task automatic test_register_sweep();
    apply_setting(1'b1, 3'd7, 16'd50, 16'd800);
    run_random_traffic(150, 60, 1'b0);
    apply_setting(1'b0, 3'd7, 16'd0, 16'd0);
    run_random_traffic(140, 5, 1'b0);
    apply_setting(1'b1, 3'b101, 16'hFFFF, 16'hFFFF);
    run_random_traffic(120, 30000, 1'b0);
    apply_setting(1'b0, 3'($urandom_range(1, 6)), 16'($urandom_range(0, 20)),
                  16'($urandom_range(0, 150)));
    no_gaps = 1'b1;
    run_random_traffic(150, 20, 1'b1);
    no_gaps = 1'b0;
    apply_setting(1'b1, 3'd0, 16'd10, 16'd40);
    run_random_traffic(30, 10, 1'b0);
    apply_setting(1'($urandom), 3'd7, 16'($urandom_range(0, 15)),
                  16'($urandom_range(5, 100)));
    run_random_traffic(250, 12, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result-side back-pressure
  initial begin
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      evt_if.ready = no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_pops
    pop_result_t want;
    if (!rst && evt_if.valid && evt_if.ready) begin
      if (evt_if.event_found) n_found++;
      else n_empty++;
      if (expected_pops.size() == 0) begin
        note_failure($sformatf("unexpected result found=%0b button=%0d action=%0b",
                               evt_if.event_found, evt_if.button, evt_if.action));
      end else begin
        want = expected_pops.pop_front();
        if (evt_if.event_found !== want.found || evt_if.button !== want.ev.button ||
            evt_if.action !== want.ev.action)
          note_failure($sformatf(
            "pop mismatch: expected found=%0b button=%0d action=%0b, got %0b/%0d/%0b",
            want.found, want.ev.button, want.ev.action,
            evt_if.event_found, evt_if.button, evt_if.action));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d pops outstanding",
               stall_cycles, expected_pops.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    no_gaps             = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = tbdl_pkg::CMD_POLL;
    cmd_if.left_level   = 1'b0;
    cmd_if.right_level  = 1'b0;
    cmd_if.center_level = 1'b0;
    cmd_if.now_ms       = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = tbdl_pkg::CFG_ACTIVE_LOW;
    cfg_if.data         = '0;
    t_now               = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_debounce_across_wrap();
    test_long_press_hold();
    test_queue_overflow();
    test_register_sweep();

    cmd_if.valid = 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d polls, %0d pops, %0d inits, %0d ignored commands",
             n_polls, n_pops, n_inits, n_ignored);
    $display("over %0d settings with %0d sender pauses; pops returned %0d events, %0d empties",
             n_settings + 1, n_pauses, n_found, n_empty);
    $display("and %0d events were dropped on a full ring", n_dropped);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tbdl_pkg.sv
rtl/tbdl_intf.sv
rtl/three_button_debounce_long_press_unit.sv
dv/tb_three_button_debounce_long_press_unit.sv
